### sv/sprite_attribute_decoder_assert.svh
// assertion macros for the sprite attribute decoder
`ifndef SPRITE_ATTRIBUTE_DECODER_ASSERT_SVH
`define SPRITE_ATTRIBUTE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked while out of reset
`define SAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, kept for conditions that hold through reset as well
`define SAD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SAD_ASSERT(label, clk, rst_n, prop, msg)
`define SAD_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/sad_pkg.sv
`default_nettype none

package sad_pkg;

  // visible screen lines
  localparam int SCREEN_LINES = 192;

  // widths of the result fields
  localparam int OFFS_W   = 18;
  localparam int STRIDE_W = 11;
  localparam int SIZE_W   = 7;

  // configuration register indexes
  localparam logic [2:0] CFG_DISPLAY_CONTROL = 3'd0;
  localparam logic [2:0] CFG_BLEND_CONTROL   = 3'd1;
  localparam logic [2:0] CFG_BLEND_COEF_A    = 3'd2;
  localparam logic [2:0] CFG_BLEND_COEF_B    = 3'd3;
  localparam logic [2:0] CFG_FADE_COEF       = 3'd4;

  // object type codes (attr word 0 bits 9:8)
  localparam logic [1:0] OBJ_NORMAL     = 2'd0;
  localparam logic [1:0] OBJ_AFFINE     = 2'd1;
  localparam logic [1:0] OBJ_DISABLED   = 2'd2;
  localparam logic [1:0] OBJ_AFFINE_DBL = 2'd3;

  // object mode codes (attr word 0 bits 11:10)
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SEMI   = 2'd1;
  localparam logic [1:0] MODE_WINDOW = 2'd2;
  localparam logic [1:0] MODE_BITMAP = 2'd3;

  // blend effect kinds
  localparam logic [1:0] FX_NONE  = 2'd0;
  localparam logic [1:0] FX_ALPHA = 2'd1;

  typedef enum logic [1:0] {
    PK_4BPP   = 2'd0,
    PK_8BPP   = 2'd1,
    PK_BITMAP = 2'd2
  } pix_kind_t;

  // fields after the first stage: decoded attributes
  typedef struct packed {
    logic signed [8:0] x;
    logic signed [7:0] y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [7:0]        bw;
    logic [7:0]        bh;
    logic [1:0]        obj_type;
    logic [1:0]        mode;
    logic              deep;
    logic [3:0]        upper;
    logic [9:0]        tile;
    logic [1:0]        flip;
  } dec_t;

  // fields after the second stage: bounds and addressing
  typedef struct packed {
    logic                vis_pre;
    logic                repl_pre;
    pix_kind_t           kind;
    logic [OFFS_W-1:0]   offs;
    logic [STRIDE_W-1:0] stride;
    logic [7:0]          pal;
    logic [SIZE_W-1:0]   w;
    logic [SIZE_W-1:0]   h;
    logic signed [8:0]   x;
    logic signed [7:0]   y;
    logic [1:0]          flip;
  } addr_t;

  // width from shape (low two bits) and size (high two bits)
  function automatic logic [SIZE_W-1:0] size_width(input logic [3:0] sz);
    logic [SIZE_W-1:0] r;
    case (sz)
      4'd0:    r = 7'd8;
      4'd1:    r = 7'd16;
      4'd2:    r = 7'd8;
      4'd4:    r = 7'd16;
      4'd5:    r = 7'd32;
      4'd6:    r = 7'd8;
      4'd8:    r = 7'd32;
      4'd9:    r = 7'd32;
      4'd10:   r = 7'd16;
      4'd12:   r = 7'd64;
      4'd13:   r = 7'd64;
      4'd14:   r = 7'd32;
      default: r = 7'd8;
    endcase
    return r;
  endfunction

  // height from shape and size
  function automatic logic [SIZE_W-1:0] size_height(input logic [3:0] sz);
    logic [SIZE_W-1:0] r;
    case (sz)
      4'd0:    r = 7'd8;
      4'd1:    r = 7'd8;
      4'd2:    r = 7'd16;
      4'd4:    r = 7'd16;
      4'd5:    r = 7'd8;
      4'd6:    r = 7'd32;
      4'd8:    r = 7'd32;
      4'd9:    r = 7'd16;
      4'd10:   r = 7'd32;
      4'd12:   r = 7'd64;
      4'd13:   r = 7'd32;
      4'd14:   r = 7'd64;
      default: r = 7'd8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/sprite_attribute_decoder.sv
`default_nettype none
// Sprite attribute decoder: takes the three attribute words of one sprite
// and returns its visibility, pixel kind, VRAM start offset, row stride,
// palette offset, size, signed position and flip bits, plus a replaceable flag.
// One item is accepted per clock while in_tready is high. Its result passes
// three register stages (decode, bounds and addressing, final combine into
// the output register) before it is on the output.
// Back-pressure on the result side stalls the stages behind it without
// dropping items. Empty stages still fill while the output waits.
// Configuration is written through cfg_we/cfg_index/cfg_wdata. Write it only
// while no item is in flight.

`include "sprite_attribute_decoder_assert.svh"

module sprite_attribute_decoder #(
  parameter int SCREEN_LINES = sad_pkg::SCREEN_LINES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // attribute item input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // attr_word0 [15:0], attr_word1 [31:16], attr_word2 [47:32]
  input  wire logic [47:0] in_tdata,
  // decoded item output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // visible [0], pixel_kind [2:1], vram_offset [20:3], row_stride [31:21],
  // palette_offset [39:32], sprite_width [46:40], sprite_height [53:47],
  // x_position [62:54], y_position [70:63], flip_bits [72:71],
  // replaceable [73], zero fill [79:74]
  output logic [79:0]      out_tdata
);

  // configuration registers
  logic [31:0] display_control_r;
  logic [7:0]  blend_control_r;
  logic [4:0]  blend_coef_a_r;
  logic [4:0]  blend_coef_b_r;
  logic [4:0]  fade_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_control_r <= '0;
      blend_control_r   <= '0;
      blend_coef_a_r    <= '0;
      blend_coef_b_r    <= '0;
      fade_coef_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sad_pkg::CFG_DISPLAY_CONTROL: display_control_r <= cfg_wdata;
        sad_pkg::CFG_BLEND_CONTROL:   blend_control_r   <= cfg_wdata[7:0];
        sad_pkg::CFG_BLEND_COEF_A:    blend_coef_a_r    <= cfg_wdata[4:0];
        sad_pkg::CFG_BLEND_COEF_B:    blend_coef_b_r    <= cfg_wdata[4:0];
        sad_pkg::CFG_FADE_COEF:       fade_coef_r       <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage takes a new item when empty or moving on
  logic dec_v_r, addr_v_r, out_v_r;
  logic out_adv, addr_rdy, dec_rdy;

  assign out_adv   = !out_v_r || out_tready;
  assign addr_rdy  = !addr_v_r || out_adv;
  assign dec_rdy   = !dec_v_r || addr_rdy;
  assign in_tready = dec_rdy;
  assign out_tvalid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r  <= 1'b0;
      addr_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (dec_rdy) dec_v_r <= in_tvalid;
      if (addr_rdy) addr_v_r <= dec_v_r;
      if (out_adv) out_v_r <= addr_v_r;
    end
  end

  // stage 1: split the words, size lookup, bounding box
  logic [15:0]    w0, w1, w2;
  logic [3:0]     sz;
  sad_pkg::dec_t  dec_nxt, dec_r;

  always_comb begin
    w0 = in_tdata[15:0];
    w1 = in_tdata[31:16];
    w2 = in_tdata[47:32];
    sz = {w1[15:14], w0[15:14]};
    dec_nxt.x        = $signed(w1[8:0]);
    dec_nxt.y        = $signed(w0[7:0]);
    dec_nxt.w        = sad_pkg::size_width(sz);
    dec_nxt.h        = sad_pkg::size_height(sz);
    dec_nxt.obj_type = w0[9:8];
    dec_nxt.mode     = w0[11:10];
    dec_nxt.deep     = w0[13];
    dec_nxt.upper    = w2[15:12];
    dec_nxt.tile     = w2[9:0];
    dec_nxt.flip     = w1[13:12];
    // double-size affine sprites cover twice the width and height
    if (w0[9:8] == sad_pkg::OBJ_AFFINE_DBL) begin
      dec_nxt.bw = {dec_nxt.w, 1'b0};
      dec_nxt.bh = {dec_nxt.h, 1'b0};
    end else begin
      dec_nxt.bw = {1'b0, dec_nxt.w};
      dec_nxt.bh = {1'b0, dec_nxt.h};
    end
  end

  always_ff @(posedge clk) begin
    if (dec_rdy) dec_r <= dec_nxt;
  end

  // stage 2: screen bounds, bitmap checks, vram addressing
  logic signed [10:0] x_end;
  logic signed [9:0]  y_s, y_end;
  logic               x_ok, y_ok, y_ok_signed, y_ok_wrap;
  logic               bitmap;
  logic [17:0]        tile18;
  logic [3:0]         tile_shift;
  sad_pkg::addr_t     addr_nxt, addr_r;

  localparam logic signed [9:0] LINES_S = 10'(SCREEN_LINES);
  localparam logic [8:0]        LINES_U = 9'(SCREEN_LINES);

  always_comb begin
    x_end = 11'(dec_r.x) + $signed({3'b000, dec_r.bw});
    x_ok  = x_end > 11'sd0;
    y_s   = 10'(dec_r.y);
    y_end = y_s + $signed({2'b00, dec_r.bh});
    y_ok_signed = (y_end > 10'sd0) && (y_s < LINES_S);
    // y read as 0..255 always ends above line 0
    y_ok_wrap   = {1'b0, dec_r.y} < LINES_U;
    y_ok   = y_ok_signed || y_ok_wrap;
    bitmap = dec_r.mode == sad_pkg::MODE_BITMAP;
    tile18 = {8'd0, dec_r.tile};

    addr_nxt.vis_pre = display_control_r[12] && (dec_r.obj_type != sad_pkg::OBJ_DISABLED)
                       && x_ok && y_ok
                       && !(bitmap && (display_control_r[6:5] == 2'b11))
                       && !(bitmap && (dec_r.upper == 4'd0));
    addr_nxt.repl_pre = !dec_r.obj_type[0] && (dec_r.mode != sad_pkg::MODE_SEMI)
                        && (dec_r.mode != sad_pkg::MODE_WINDOW);

    tile_shift = 4'd0;
    if (bitmap) begin
      addr_nxt.kind = sad_pkg::PK_BITMAP;
      addr_nxt.pal  = {4'd0, dec_r.upper} + 8'd1;
      if (display_control_r[6]) begin
        // bitmap 1D mapping
        tile_shift      = 4'd7 + {3'b000, display_control_r[22]};
        addr_nxt.offs   = tile18 << tile_shift;
        addr_nxt.stride = {3'b000, dec_r.w, 1'b0};
      end else if (display_control_r[5]) begin
        // bitmap 2D, 256 pixels wide
        addr_nxt.offs   = {9'd0, dec_r.tile[4:0], 4'd0}
                          + {1'b0, dec_r.tile[9:5], 12'd0};
        addr_nxt.stride = 11'd512;
      end else begin
        // bitmap 2D, 128 pixels wide
        addr_nxt.offs   = {10'd0, dec_r.tile[3:0], 4'd0}
                          + {1'b0, dec_r.tile[9:4], 11'd0};
        addr_nxt.stride = 11'd256;
      end
    end else begin
      if (display_control_r[4]) begin
        // tiled 1D mapping with boundary shift
        tile_shift      = 4'd5 + {2'b00, display_control_r[21:20]};
        addr_nxt.offs   = tile18 << tile_shift;
        addr_nxt.stride = dec_r.deep ? {1'b0, dec_r.w[6:3], 6'd0}
                                     : {2'b00, dec_r.w[6:3], 5'd0};
      end else begin
        addr_nxt.offs   = {3'd0, dec_r.tile, 5'd0};
        addr_nxt.stride = 11'd1024;
      end
      if (dec_r.deep) begin
        addr_nxt.kind = sad_pkg::PK_8BPP;
        addr_nxt.pal  = display_control_r[31] ? ({4'd0, dec_r.upper} + 8'd1) : 8'd0;
      end else begin
        addr_nxt.kind = sad_pkg::PK_4BPP;
        addr_nxt.pal  = {dec_r.upper, 4'd0};
      end
    end

    addr_nxt.w    = dec_r.w;
    addr_nxt.h    = dec_r.h;
    addr_nxt.x    = dec_r.x;
    addr_nxt.y    = dec_r.y;
    addr_nxt.flip = dec_r.flip;
  end

  always_ff @(posedge clk) begin
    if (addr_rdy) addr_r <= addr_nxt;
  end

  // stage 3: color effect on the object layer, final flags
  logic [1:0]  fx_kind;
  logic        fx_active;
  logic        repl;
  logic [79:0] out_nxt, out_data_r;

  always_comb begin
    fx_kind   = blend_control_r[7:6];
    fx_active = blend_control_r[4] && (fx_kind != sad_pkg::FX_NONE);
    if ((fx_kind == sad_pkg::FX_ALPHA) && blend_coef_a_r[4] && (blend_coef_b_r == 5'd0))
      fx_active = 1'b0;
    if (fx_kind[1] && (fade_coef_r == 5'd0))
      fx_active = 1'b0;
    repl = addr_r.vis_pre && addr_r.repl_pre && !fx_active;
    out_nxt = {6'd0, repl, addr_r.flip, addr_r.y, addr_r.x, addr_r.h, addr_r.w,
               addr_r.pal, addr_r.stride, addr_r.offs, addr_r.kind, addr_r.vis_pre};
  end

  always_ff @(posedge clk) begin
    if (out_adv) out_data_r <= out_nxt;
  end

  assign out_tdata = out_data_r;

  // checks
  `SAD_ASSERT(a_vis_needs_enable, clk, rst_n,
    (out_tvalid && out_tdata[0]) |-> display_control_r[12],
    "visible item with objects disabled")
  `SAD_ASSERT(a_repl_needs_vis, clk, rst_n,
    (out_tvalid && out_tdata[73]) |-> out_tdata[0],
    "replaceable item that is not visible")
  `SAD_ASSERT(a_bitmap_map_ok, clk, rst_n,
    (out_tvalid && out_tdata[0] && (out_tdata[2:1] == sad_pkg::PK_BITMAP))
      |-> (display_control_r[6:5] != 2'b11),
    "visible bitmap item with forbidden mapping")
  `SAD_ASSERT_ALWAYS(a_out_held, clk,
    (rst_n && $past(rst_n) && $past(out_tvalid) && !$past(out_tready))
      |-> (out_tvalid && $stable(out_data_r)),
    "stalled result changed")

endmodule

`default_nettype wire
